>>> rtl/sha8_pkg.sv
// Package with SHA-512 constants, types and round functions for the eight-lane hash.
package sha8_pkg;

  localparam int DefLanes = 8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PRIOR = 2'd2,
    CMD_MSG   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } state_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       init;
    logic       round;
    logic [6:0] rnd;
  } rctl_t;

  function automatic logic [63:0] iv_word(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  localparam logic [63:0] RC [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int r);
    return (x >> r) | (x << (64 - r));
  endfunction

endpackage

>>> rtl/sha8_lane.sv
// One lane of SHA-512: message schedule window, working variables and chaining value.
module sha8_lane
  import sha8_pkg::*;
(
  input  logic        clk,
  input  rctl_t       ctl,
  input  logic        shift_in,
  input  logic [63:0] word_in,
  input  logic        chain_wr,
  input  logic [2:0]  chain_idx,
  input  logic [63:0] chain_val,
  input  logic        chain_iv,
  input  logic        feed,
  input  logic [2:0]  rd_idx,
  output logic [63:0] rd_word
);

  logic [63:0] w [16];
  logic [63:0] v [8];
  logic [63:0] h [8];
  logic [63:0] w_new, wt, t1, t2, e, a;

  assign e  = v[4];
  assign a  = v[0];
  assign wt = w[0];
  assign w_new = (rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6)) + w[9]
               + (rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7)) + w[0];
  assign t1 = v[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
            + ((e & v[5]) ^ (~e & v[6])) + RC[ctl.rnd] + wt;
  assign t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
            + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  assign rd_word = h[rd_idx];

  always_ff @(posedge clk) begin
    if (shift_in || ctl.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= shift_in ? word_in : w_new;
    end
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (chain_iv) begin
      for (int i = 0; i < 8; i++) h[i] <= iv_word(3'(i));
    end else if (chain_wr) begin
      h[chain_idx] <= chain_val;
    end else if (feed) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end
  end

endmodule

>>> rtl/sha8_ctrl.sv
// Sequencer: block fill, padding words, round count and digest output.
module sha8_ctrl
  import sha8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  logic [1:0]  cmd,
  input  logic [63:0] lane0,
  input  logic [3:0]  vb_in,
  input  logic        last_in,
  input  logic        out_take,
  output logic        busy,
  output rctl_t       ctl,
  output logic        shift_in,
  output logic        use_lane,
  output logic [63:0] mask,
  output logic [63:0] pad_or,
  output logic [63:0] fill_word,
  output logic        feed,
  output logic        out_valid,
  output logic [2:0]  out_idx
);

  state_t      state, state_next;
  logic [63:0] bit_length, total;
  logic [3:0]  fill;
  logic [6:0]  rnd;
  logic        fin, pad80;
  logic        len_here, len_sent, len_word;
  logic        init;
  logic [3:0]  vb;
  logic [2:0]  oidx;

  assign busy = state != ST_IDLE;
  assign vb = (vb_in > 4'd8) ? 4'd8 : vb_in;
  assign mask = (vb == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {vb, 3'b000});
  assign pad_or = (vb < 4'd8) ? (64'h80 << (7'd56 - {vb, 3'b000})) : 64'd0;
  assign out_valid = state == ST_OUT;
  assign out_idx = oidx;
  assign ctl.rnd = rnd;
  assign ctl.round = state == ST_ROUND;
  assign ctl.init = init;
  assign feed = state == ST_FEED;
  assign len_word = state == ST_PAD && !pad80 && fill == 4'd15 && len_here;

  logic msg_acc;
  assign msg_acc = acc && cmd == CMD_MSG;

  always_comb begin
    shift_in  = 1'b0;
    use_lane  = 1'b0;
    fill_word = 64'd0;
    init      = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (msg_acc) begin
          shift_in = 1'b1;
          use_lane = 1'b1;
          if (fill == 4'd15) begin
            init = 1'b1;
            state_next = ST_ROUND;
          end else if (last_in) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_in = 1'b1;
        if (pad80) fill_word = 64'h8000000000000000;
        else if (len_word) fill_word = total;
        if (fill == 4'd15) begin
          init = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: if (rnd == 7'd79) state_next = ST_FEED;
      ST_FEED: begin
        if (fin && len_sent) state_next = ST_OUT;
        else if (fin) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_OUT: if (out_take && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bit_length <= 64'd0;
      fill <= 4'd0;
      rnd <= 7'd0;
      fin <= 1'b0;
      pad80 <= 1'b0;
      len_here <= 1'b0;
      len_sent <= 1'b0;
      oidx <= 3'd0;
    end else begin
      state <= state_next;
      rnd <= (state == ST_ROUND) ? rnd + 7'd1 : 7'd0;
      if (shift_in) fill <= fill + 4'd1;
      if (state == ST_FEED) bit_length <= bit_length + 64'd1024;
      if (acc && cmd == CMD_START) begin
        bit_length <= 64'd0;
        fill <= 4'd0;
      end
      if (acc && cmd == CMD_PRIOR) begin
        bit_length <= {lane0[53:0], 10'd0};
        fill <= 4'd0;
      end
      if (msg_acc && last_in) begin
        fin <= 1'b1;
        pad80 <= vb == 4'd8;
        len_here <= (vb != 4'd8) && (fill <= 4'd13);
        len_sent <= 1'b0;
        total <= bit_length + {54'd0, fill, 6'd0} + {57'd0, vb, 3'd0};
      end else if (state == ST_PAD) begin
        pad80 <= 1'b0;
        // A marker in one of the last two slots pushes the length into one more block.
        if (pad80) len_here <= (fill <= 4'd13);
        if (len_word) len_sent <= 1'b1;
      end else if (state == ST_FEED && fin) begin
        len_here <= 1'b1;
      end
      if (state == ST_OUT) begin
        if (out_take) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            fin <= 1'b0;
            len_sent <= 1'b0;
            bit_length <= 64'd0;
            fill <= 4'd0;
          end
        end
      end
    end
  end

endmodule

>>> rtl/sha8_eight_lane_top_dummy.sv
// Output register that holds one digest word of every lane until it is taken.
module sha8_out
  import sha8_pkg::*;
#(
  parameter int Lanes = DefLanes
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [Lanes*64-1:0]   d,
  input  logic [2:0]            idx,
  input  logic                  take,
  output logic                  valid,
  output logic [Lanes*64+2:0]   q
);
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (load) valid <= 1'b1;
    else if (take) valid <= 1'b0;
    if (load) q <= {d, idx};
  end
endmodule

>>> rtl/sha512_eight_lane_hash.sv
// Top level of the eight-lane SHA-512 hasher.
// Commands and message words are taken only while idle; a word that fills the
// 16-word block then runs 80 rounds on one shared round datapath per lane
// plus a feed-forward step. A last word also inserts padding words
// one per cycle, finishing the current block and, when the 0x80 marker lands in one
// of its last two slots, one more block, and then sends eight digest transfers, one
// per cycle when the sink is ready. Input is held off while busy, so sustained
// throughput is set by the one-round-per-cycle compression loop.
module sha512_eight_lane_hash
  import sha8_pkg::*;
#(
  parameter int LANES = DefLanes
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: cmd, word_index, lane_0..lane_N, valid_bytes, zero fill
  input  logic [((LANES*64+9+7)/8)*8-1:0] s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: digest_index, digest_0..digest_N, zero fill
  output logic [((LANES*64+3+7)/8)*8-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int DW = ((LANES*64+3+7)/8)*8;

  logic        busy, acc, shift_in, use_lane, feed, cvalid, take;
  logic [1:0]  cmd;
  logic [2:0]  widx, oidx;
  logic [3:0]  vb;
  logic [63:0] mask, pad_or, fill_word;
  rctl_t       ctl;
  logic [LANES*64-1:0] dig;
  logic [LANES*64+2:0] oq;
  logic        ovalid;

  assign cmd  = s_tdata[1:0];
  assign widx = s_tdata[4:2];
  assign vb   = s_tdata[LANES*64+8:LANES*64+5];
  assign s_tready = !busy;
  assign acc = s_tvalid && s_tready;
  assign take = cvalid && (!ovalid || m_tready);

  sha8_ctrl u_ctrl (
    .clk, .rst, .acc, .cmd, .lane0(s_tdata[68:5]), .vb_in(vb), .last_in(s_tlast),
    .out_take(take), .busy, .ctl, .shift_in, .use_lane, .mask, .pad_or, .fill_word,
    .feed, .out_valid(cvalid), .out_idx(oidx)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [63:0] win;
    assign win = use_lane ? (s_tlast ? ((s_tdata[5+64*l +: 64] & mask) | pad_or)
                                     : s_tdata[5+64*l +: 64])
                          : fill_word;
    sha8_lane u_lane (
      .clk, .ctl, .shift_in, .word_in(win),
      .chain_wr(acc && cmd == CMD_LOAD), .chain_idx(widx), .chain_val(s_tdata[68:5]),
      .chain_iv(rst || (acc && cmd == CMD_START)), .feed, .rd_idx(oidx),
      .rd_word(dig[64*l +: 64])
    );
  end

  sha8_out #(.Lanes(LANES)) u_out (
    .clk, .rst, .load(take), .d(dig), .idx(oidx), .take(m_tready && ovalid),
    .valid(ovalid), .q(oq)
  );

  assign m_tvalid = ovalid;
  assign m_tdata  = DW'(oq);
  assign m_tlast  = oq[2:0] == 3'd7;

  assert property (@(posedge clk) disable iff (rst) busy |-> !acc)
    else $error("input accepted while busy");
  assert property (@(posedge clk) disable iff (rst) ctl.round |-> !shift_in)
    else $error("round and load overlap");
  assert property (@(posedge clk) disable iff (rst) cvalid |-> busy)
    else $error("digest shown while idle");
  assert property (@(posedge clk) disable iff (rst)
                   m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

endmodule
